// ===== rtl/core/clsr_pkg.sv =====
// Shared constants, command/status types and the modular fold function
// for the combined LCG shuffled uniform generator. No dependencies.
package clsr_pkg;

  localparam int TABLE_SIZE = 32;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int STEPS      = TABLE_SIZE + 8;      // warm-up plus table fill
  localparam int CNT_W      = $clog2(STEPS);

  localparam int VAL_W  = 31;
  localparam int MUL_W  = 16;
  localparam int FOLD_W = 8;
  localparam int PROD_W = VAL_W + MUL_W;

  localparam logic [VAL_W-1:0]  MOD_A = 31'd2147483563;
  localparam logic [VAL_W-1:0]  MOD_B = 31'd2147483399;
  localparam logic [MUL_W-1:0]  MUL_A = 16'd40014;
  localparam logic [MUL_W-1:0]  MUL_B = 16'd40692;
  // 2^31 - modulus, so that h*2^31 + l folds to h*FOLD + l
  localparam logic [FOLD_W-1:0] FOLD_A = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD_B = 8'd249;

  localparam logic [VAL_W-1:0] GEN_TWO_RST = 31'd123456789;
  localparam logic [VAL_W-1:0] SPAN        = MOD_A - 31'd1;

  // table index = mix / BUCKET, done as a reciprocal multiply plus one fix-up
  localparam longint SPAN_L   = 64'd2147483562;
  localparam int     BKT_W    = VAL_W + 1;
  localparam logic [BKT_W-1:0] BUCKET = BKT_W'(64'd1 + SPAN_L / TABLE_SIZE);
  localparam int     RECIP_SH = 40;
  localparam int     RECIP_W  = 17;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / BUCKET);
  localparam int     QP_W     = VAL_W + RECIP_W;
  localparam int     Q_W      = QP_W - RECIP_SH;

  typedef struct packed {
    logic             load;     // item accepted
    logic             reseed;   // load seed into both generators
    logic             mul;      // launch generator and index products
    logic             sstep;    // seeding step: commit gen_one
    logic             swr;      // seeding step writes the table
    logic [IDX_W-1:0] sidx;     // table entry for seeding write
    logic             slast;    // last seeding step: load mix
    logic             dred;     // draw: commit generators, read table
    logic             fin;      // draw: combine, write table, load output
  } clsr_cmd_t;

  typedef struct packed {
    logic gen_one_zero;
  } clsr_stat_t;

  function automatic logic [VAL_W-1:0] mod_fold(input logic [PROD_W-1:0] p,
                                                input logic [FOLD_W-1:0] fold,
                                                input logic [VAL_W-1:0]  m);
    logic [MUL_W-1:0]        h;
    logic [MUL_W+FOLD_W-1:0] hf;
    logic [VAL_W:0]          s;
    h  = p[PROD_W-1:VAL_W];
    hf = h * fold;
    s  = {1'b0, p[VAL_W-1:0]} + (VAL_W+1)'(hf);
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

// ===== rtl/core/clsr_req_if.sv =====
// Request channel: valid/ready plus func and seed_value.
// Depends on clsr_pkg.
interface clsr_req_if import clsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [VAL_W-1:0] seed_value;

  modport source (output valid, func, seed_value, input ready);
  modport sink   (input valid, func, seed_value, output ready);
endinterface

// ===== rtl/core/clsr_rsp_if.sv =====
// Result channel: valid/ready plus rand_value.
// Depends on clsr_pkg.
interface clsr_rsp_if import clsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] rand_value;

  modport source (output valid, rand_value, input ready);
  modport sink   (input valid, rand_value, output ready);
endinterface

// ===== rtl/core/clsr_datapath.sv =====
// Datapath: both generators, modular multipliers, index divider,
// shuffle table memory and output register. Depends on clsr_pkg.
module clsr_datapath import clsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  clsr_cmd_t        cmd_i,
  input  logic             func_i,
  input  logic [VAL_W-1:0] seed_value_i,
  output clsr_stat_t       stat_o,
  output logic [VAL_W-1:0] rand_value_o
);

  logic [VAL_W-1:0]  gen_one_q, gen_two_q, mix_q;
  logic [PROD_W-1:0] p1_q, p2_q;
  logic [QP_W-1:0]   qp_q;
  logic [IDX_W-1:0]  idx_q;
  logic [VAL_W-1:0]  rd_q;
  logic [VAL_W-1:0]  rand_q;
  logic [VAL_W-1:0]  tbl [TABLE_SIZE];

  logic [VAL_W-1:0]       seed_eff, g1n, g2n;
  logic [Q_W-1:0]         q0;
  logic [Q_W:0]           qn, qsel;
  logic [Q_W+BKT_W:0]     chk;
  logic [IDX_W-1:0]       idx;
  logic signed [VAL_W:0]  diff, mix_adj;
  logic                   we;
  logic [IDX_W-1:0]       wa;
  logic [VAL_W-1:0]       wd;

  assign seed_eff = (func_i && seed_value_i != '0) ? seed_value_i : VAL_W'(1);
  assign g1n      = mod_fold(p1_q, FOLD_A, MOD_A);
  assign g2n      = mod_fold(p2_q, FOLD_B, MOD_B);

  // reciprocal estimate is low by at most one
  always_comb begin
    q0   = qp_q[QP_W-1:RECIP_SH];
    qn   = {1'b0, q0} + (Q_W+1)'(1);
    chk  = qn * BUCKET;
    qsel = (chk <= (Q_W+BKT_W+1)'(mix_q)) ? qn : {1'b0, q0};
    if (qsel > (Q_W+1)'(TABLE_SIZE - 1)) begin
      idx = IDX_W'(TABLE_SIZE - 1);
    end else begin
      idx = qsel[IDX_W-1:0];
    end
  end

  always_comb begin
    diff = $signed({1'b0, rd_q}) - $signed({1'b0, gen_two_q});
    if (diff < 1) begin
      mix_adj = diff + $signed({1'b0, SPAN});
    end else begin
      mix_adj = diff;
    end
  end

  assign we = (cmd_i.sstep && cmd_i.swr) || cmd_i.fin;
  assign wa = cmd_i.fin ? idx_q : cmd_i.sidx;
  assign wd = cmd_i.fin ? gen_one_q : g1n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_one_q <= '0;
      gen_two_q <= GEN_TWO_RST;
      mix_q     <= '0;
    end else begin
      if (cmd_i.load && cmd_i.reseed) begin
        gen_one_q <= seed_eff;
        gen_two_q <= seed_eff;
      end
      if (cmd_i.sstep) begin
        gen_one_q <= g1n;
        if (cmd_i.slast) begin
          mix_q <= g1n;
        end
      end
      if (cmd_i.dred) begin
        gen_one_q <= g1n;
        gen_two_q <= g2n;
      end
      if (cmd_i.fin) begin
        mix_q <= mix_adj[VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p1_q <= gen_one_q * MUL_A;
      p2_q <= gen_two_q * MUL_B;
      qp_q <= mix_q * RECIP;
    end
    if (cmd_i.dred) begin
      idx_q <= idx;
      rd_q  <= tbl[idx];
    end
    if (we) begin
      tbl[wa] <= wd;
    end
    if (cmd_i.fin) begin
      rand_q <= mix_adj[VAL_W-1:0];
    end
  end

  assign stat_o.gen_one_zero = (gen_one_q == '0);
  assign rand_value_o        = rand_q;

endmodule

// ===== rtl/core/clsr_ctrl.sv =====
// Controller: sequences seeding steps and draws, owns the handshakes.
// Depends on clsr_pkg.
module clsr_ctrl import clsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_func_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  clsr_stat_t stat_i,
  output clsr_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SMUL = 3'd1;
  localparam logic [2:0] S_SRED = 3'd2;
  localparam logic [2:0] S_DMUL = 3'd3;
  localparam logic [2:0] S_DRED = 3'd4;
  localparam logic [2:0] S_DFIN = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, reseed, out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign reseed     = in_func_i || stat_i.gen_one_zero;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.sidx  = cnt_q[IDX_W-1:0];
    cmd_o.swr   = (cnt_q < CNT_W'(TABLE_SIZE));
    cmd_o.slast = (cnt_q == '0);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load   = 1'b1;
          cmd_o.reseed = reseed;
          cnt_d        = CNT_W'(STEPS - 1);
          state_d      = reseed ? S_SMUL : S_DMUL;
        end
      end
      S_SMUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SRED;
      end
      S_SRED: begin
        cmd_o.sstep = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DMUL;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_SMUL;
        end
      end
      S_DMUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DRED;
      end
      S_DRED: begin
        cmd_o.dred = 1'b1;
        state_d    = S_DFIN;
      end
      S_DFIN: begin
        // hold until the output register can take the new item
        if (out_free) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/combined_lcg_shuffled_uniform_rng_core.sv =====
// Combined LCG uniform generator with Bays-Durham shuffle.
// Top level of the controller/datapath pair. Depends on clsr_pkg,
// clsr_req_if, clsr_rsp_if, clsr_ctrl and clsr_datapath.
//
// Usage: each item on req_i asks for one draw; func=1 reseeds from
// seed_value first (0 counts as 1). One item on rsp_o carries rand_value,
// 1..2147483562 (uniform = value / 2147483563).
// After the accept a draw steps through DMUL, DRED and DFIN, then goes
// back to idle; the result and its valid are registered as DFIN ends.
// A reseed first runs TABLE_SIZE+8 warm-up/fill steps; each step forms
// the first generator's product (SMUL), then folds and commits it (SRED).
// The first draw after reset, or any draw while the first generator holds
// zero, reseeds with 1 and so takes the reseed time too.
// Reset clears the controller, the output valid and the generator state;
// the shuffle table needs no clearing since it is always filled first.
// The result sits in an output register: a new item is accepted while it
// waits, and the following draw holds in its last step until rsp_o is taken.
module combined_lcg_shuffled_uniform_rng_core import clsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  clsr_req_if.sink    req_i,
  clsr_rsp_if.source  rsp_o
);

  clsr_cmd_t  cmd;
  clsr_stat_t stat;

  clsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_func_i   (req_i.func),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  clsr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .func_i       (req_i.func),
    .seed_value_i (req_i.seed_value),
    .stat_o       (stat),
    .rand_value_o (rsp_o.rand_value)
  );

endmodule
